// ===== rtl/core/rcu_grace_period_tracker_unit_assert.svh =====
// Assertion macros for the grace-period tracker.
// Used by the top level; needs no other file.
`ifndef RCU_GRACE_PERIOD_TRACKER_UNIT_ASSERT_SVH
`define RCU_GRACE_PERIOD_TRACKER_UNIT_ASSERT_SVH
// Check that a condition implies a consequence in the same cycle.
`define RGPT_ASSERT_IMPL(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error(msg);
// Check that a condition implies a consequence in the next cycle.
`define RGPT_ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error(msg);
`endif

// ===== rtl/core/rgpt_pkg.sv =====
// Package for the grace-period tracker: types, codes and constants.
// Used by every module of the block.
`default_nettype none
package rgpt_pkg;
   localparam int NCPU_DEF       = 8;
   localparam int COUNT_BITS_DEF = 16;
   localparam int BATCH_BITS     = 16;
   localparam int PERIOD_BITS    = 17;
   localparam int CPU_BITS       = 3;
   localparam int MODE_BITS      = 3;
   localparam int CSR_IDX_BITS   = 3;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [BATCH_BITS-1:0]  BATCH_RESET = 16'd65236;
   localparam logic [PERIOD_BITS-1:0] PERIOD_MAX  = 17'd100000;
   localparam logic [PERIOD_BITS-1:0] PERIOD_DEF  = 17'd10000;
   localparam logic [PERIOD_BITS-1:0] PERIOD_MIN  = 17'd100;
   localparam logic [PERIOD_BITS-1:0] PERIOD_INC  = 17'd10000;
   localparam logic [PERIOD_BITS-1:0] PERIOD_DEC  = 17'd100;

   localparam logic [MODE_BITS-1:0] MODE_ENQUEUE   = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_PROCESS   = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_IDLE_IN   = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_IDLE_OUT  = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_OFFLINE   = 3'd4;
   localparam logic [MODE_BITS-1:0] MODE_ONLINE    = 3'd5;
   localparam logic [MODE_BITS-1:0] MODE_TIMER     = 3'd6;
   localparam logic [MODE_BITS-1:0] MODE_NONE      = 3'd7;

   localparam logic [CSR_IDX_BITS-1:0] CSR_BATCH_LIMIT = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HIGH_MARK   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_LOW_MARK    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_KICK_IVL    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ONLINE      = 3'd4;

   // One input item.
   typedef struct packed {
      logic [MODE_BITS-1:0] mode;
      logic [CPU_BITS-1:0]  cpu;
      logic [CPU_BITS-1:0]  target_cpu;
   } req_type;

   // One result item.
   typedef struct packed {
      logic [15:0]            invoked_count;
      logic                   more_done;
      logic [7:0]             kick_mask;
      logic                   self_kick;
      logic                   work_pending;
      logic                   needs_cpu;
      logic                   batch_completed;
      logic [BATCH_BITS-1:0]  current_batch_out;
      logic [BATCH_BITS-1:0]  completed_batch_out;
      logic [PERIOD_BITS-1:0] idle_period_us;
   } rsp_type;

   // Configuration register values.
   typedef struct packed {
      logic [9:0]  batch_limit;
      logic [15:0] high_mark;
      logic [15:0] low_mark;
      logic [15:0] kick_interval;
      logic [7:0]  online_mask;
   } cfg_type;

   // True when batch a is ordered before batch b.
   function automatic logic batch_before(input logic [BATCH_BITS-1:0] a,
                                         input logic [BATCH_BITS-1:0] b);
      logic [BATCH_BITS-1:0] d;
      d = a - b;
      return d[BATCH_BITS-1];
   endfunction
endpackage
`default_nettype wire

// ===== rtl/core/rgpt_req_if.sv =====
// Valid/ready channel interface for the tracker's input items.
// Depends on rgpt_pkg.
`default_nettype none
interface rgpt_req_if import rgpt_pkg::*; ();
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rgpt_rsp_if.sv =====
// Valid/ready channel interface for the tracker's result items.
// Depends on rgpt_pkg.
`default_nettype none
interface rgpt_rsp_if import rgpt_pkg::*; ();
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rgpt_csr.sv =====
// Configuration registers of the tracker.
// Depends on rgpt_pkg.
`default_nettype none
module rgpt_csr import rgpt_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_write,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_data,
   output cfg_type                       cfg
);
   cfg_type cfg_ff, cfg_in;

   // Decode the register index of a write.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_BATCH_LIMIT: cfg_in.batch_limit   = csr_data[9:0];
            CSR_HIGH_MARK:   cfg_in.high_mark     = csr_data;
            CSR_LOW_MARK:    cfg_in.low_mark      = csr_data;
            CSR_KICK_IVL:    cfg_in.kick_interval = csr_data;
            CSR_ONLINE:      cfg_in.online_mask   = csr_data[7:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.batch_limit   <= 10'd10;
         cfg_ff.high_mark     <= 16'd10000;
         cfg_ff.low_mark      <= 16'd100;
         cfg_ff.kick_interval <= 16'd1000;
         cfg_ff.online_mask   <= 8'd1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule
`default_nettype wire

// ===== rtl/core/rgpt_core.sv =====
// State and single-pass update logic of the grace-period tracker.
// Depends on rgpt_pkg; fed by the input register of the top level.
`default_nettype none
module rgpt_core import rgpt_pkg::*; #(
   parameter int NCPU       = NCPU_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step,
   input  wire req_type req,
   input  wire cfg_type cfg,
   output rsp_type      rsp
);
   localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
   localparam int CB = COUNT_BITS;

   logic [BATCH_BITS-1:0]  cur_ff, cur_in, comp_ff, comp_in;
   logic                   pend_ff, pend_in;
   logic [NCPU-1:0]        wait_ff, wait_in, idle_ff, idle_in;
   logic [PERIOD_BITS-1:0] per_ff, per_in;
   logic [BATCH_BITS-1:0]  seen_ff [NCPU];
   logic [BATCH_BITS-1:0]  wb_ff   [NCPU];
   logic [CB-1:0]          newc_ff [NCPU];
   logic [CB-1:0]          curc_ff [NCPU];
   logic [CB-1:0]          done_ff [NCPU];
   logic [CB-1:0]          qlen_ff [NCPU];
   logic [CB-1:0]          lkick_ff[NCPU];
   logic [NCPU-1:0]        owed_ff, lift_ff, armed_ff;

   // Next values of the addressed processor's entry and the target's.
   logic [BATCH_BITS-1:0] seen_c, wb_c;
   logic [CB-1:0]         newc_c, curc_c, done_c, qlen_c, lkick_c;
   logic                  owed_c, lift_c, armed_c;
   logic [CB-1:0]         newc_t, qlen_t;
   logic                  wr_c, wr_t;
   logic                  cflag;
   rsp_type               r;

   function automatic logic [CB-1:0] sat_add(input logic [CB-1:0] a,
                                             input logic [CB-1:0] b);
      logic [CB:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[CB] ? CMAX : s[CB-1:0];
   endfunction

   logic                  valid;
   logic [CPU_BITS-1:0]   c, t;
   logic [NCPU-1:0]       bit_c, online;
   logic [CB-1:0]         lim, inv, m1, qt;
   logic [CB+1:0]         diff;
   logic                  wmask_zero;

   assign online = NCPU'(cfg.online_mask);

   always_comb begin
      c = req.cpu;
      t = req.target_cpu;
      valid = (32'(c) < NCPU) && (req.mode != MODE_OFFLINE || 32'(t) < NCPU);
      bit_c = NCPU'(1) << c;
      cur_in = cur_ff; comp_in = comp_ff; pend_in = pend_ff;
      wait_in = wait_ff; idle_in = idle_ff; per_in = per_ff;
      seen_c = seen_ff[c[$clog2(NCPU)-1:0]];
      wb_c = wb_ff[c[$clog2(NCPU)-1:0]];
      newc_c = newc_ff[c[$clog2(NCPU)-1:0]];
      curc_c = curc_ff[c[$clog2(NCPU)-1:0]];
      done_c = done_ff[c[$clog2(NCPU)-1:0]];
      qlen_c = qlen_ff[c[$clog2(NCPU)-1:0]];
      lkick_c = lkick_ff[c[$clog2(NCPU)-1:0]];
      owed_c = owed_ff[c[$clog2(NCPU)-1:0]];
      lift_c = lift_ff[c[$clog2(NCPU)-1:0]];
      armed_c = armed_ff[c[$clog2(NCPU)-1:0]];
      newc_t = newc_ff[t[$clog2(NCPU)-1:0]];
      qlen_t = qlen_ff[t[$clog2(NCPU)-1:0]];
      wr_c = 1'b0; wr_t = 1'b0; cflag = 1'b0;
      lim = '0; inv = '0; m1 = '0; qt = '0; diff = '0; wmask_zero = 1'b0;
      r = '0;
      if (valid) begin
         wr_c = 1'b1;
         case (req.mode)
            MODE_ENQUEUE: begin
               newc_c = sat_add(newc_c, CB'(1));
               qlen_c = sat_add(qlen_c, CB'(1));
               if ({16'd0, qlen_c} > {CB'(0), cfg.high_mark}) begin
                  lift_c = 1'b1;
                  r.self_kick = 1'b1;
                  diff = {2'b0, qlen_c} - {2'b0, lkick_c};
                  if (!diff[CB+1] && diff > (CB+2)'({16'd0, cfg.kick_interval})) begin
                     lkick_c = qlen_c;
                     r.kick_mask = 8'(wait_ff & ~bit_c);
                  end
               end
            end
            MODE_PROCESS: begin
               if (curc_c != '0 && !batch_before(comp_ff, wb_c)) begin
                  done_c = sat_add(done_c, curc_c);
                  curc_c = '0;
               end
               if (newc_c != '0 && curc_c == '0) begin
                  curc_c = newc_c;
                  newc_c = '0;
                  wb_c = cur_ff + 16'd1;
                  if (!pend_ff) begin
                     if (comp_ff == cur_ff) begin
                        cur_in = cur_ff + 16'd1;
                        wait_in = online & ~idle_ff;
                     end else begin
                        pend_in = 1'b1;
                     end
                  end
               end
               if (seen_c != cur_in) begin
                  owed_c = 1'b1;
                  seen_c = cur_in;
               end else if (owed_c) begin
                  owed_c = 1'b0;
                  wait_in = wait_in & ~bit_c;
                  if (wait_in == '0) begin
                     cflag = comp_in != cur_in;
                     comp_in = cur_in;
                     if (pend_in) begin
                        pend_in = 1'b0;
                        cur_in = cur_in + 16'd1;
                        wait_in = online & ~idle_ff;
                     end
                  end
               end
               if (done_c != '0) begin
                  lim = (cfg.batch_limit == 10'd0) ? CB'(1) : CB'(cfg.batch_limit);
                  inv = done_c;
                  if (!lift_c && inv > lim) inv = lim;
                  done_c = done_c - inv;
                  qlen_c = (qlen_c > inv) ? qlen_c - inv : '0;
                  if (lift_c && {16'd0, qlen_c} <= {CB'(0), cfg.low_mark}) lift_c = 1'b0;
                  if (done_c != '0) begin
                     r.more_done = 1'b1;
                     r.self_kick = 1'b1;
                  end
               end
               r.invoked_count = 16'(inv);
            end
            MODE_IDLE_IN: begin
               idle_in = idle_ff | bit_c;
               if (curc_c != '0) armed_c = 1'b1;
            end
            MODE_IDLE_OUT: begin
               armed_c = 1'b0;
               idle_in = idle_ff & ~bit_c;
            end
            MODE_OFFLINE: begin
               armed_c = 1'b0;
               if (cur_ff != comp_ff) begin
                  wait_in = wait_ff & ~bit_c;
                  if (wait_in == '0) begin
                     cflag = 1'b1;
                     comp_in = cur_ff;
                     if (pend_ff) begin
                        pend_in = 1'b0;
                        cur_in = cur_ff + 16'd1;
                        wait_in = online & ~idle_ff;
                     end
                  end
               end
               m1 = sat_add(sat_add(done_c, curc_c), newc_c);
               qt = qlen_c;
               done_c = '0; curc_c = '0; newc_c = '0; qlen_c = '0;
               if (t == c) begin
                  newc_c = m1;
                  qlen_c = qt;
               end else begin
                  wr_t = 1'b1;
                  newc_t = sat_add(newc_t, m1);
                  qlen_t = sat_add(qlen_t, qt);
               end
            end
            MODE_ONLINE: begin
               seen_c = comp_ff; owed_c = 1'b0; wb_c = '0;
               newc_c = '0; curc_c = '0; done_c = '0; qlen_c = '0; lkick_c = '0;
               lift_c = 1'b0; armed_c = 1'b0;
            end
            MODE_TIMER: begin
               wmask_zero = wait_ff == '0;
               if (!wmask_zero)
                  per_in = (per_ff + PERIOD_INC > PERIOD_MAX) ? PERIOD_MAX
                                                             : per_ff + PERIOD_INC;
               else
                  per_in = (per_ff < PERIOD_MIN + PERIOD_DEC) ? PERIOD_MIN
                                                             : per_ff - PERIOD_DEC;
            end
            default: wr_c = 1'b1;
         endcase
         r.work_pending = (curc_c != '0 && !batch_before(comp_in, wb_c)) ||
                          (curc_c == '0 && newc_c != '0) || (done_c != '0) ||
                          (seen_c != cur_in) || owed_c;
         r.needs_cpu = (curc_c != '0 && !armed_c) || r.work_pending;
      end
      r.batch_completed = cflag;
      r.current_batch_out = cur_in;
      r.completed_batch_out = comp_in;
      r.idle_period_us = per_in;
   end

   assign rsp = r;

   // Global and per-processor state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= BATCH_RESET; comp_ff <= BATCH_RESET; pend_ff <= 1'b0;
         wait_ff <= '0; idle_ff <= '0; per_ff <= PERIOD_DEF;
         owed_ff <= '0; lift_ff <= '0; armed_ff <= '0;
         for (int i = 0; i < NCPU; i++) begin
            seen_ff[i] <= BATCH_RESET;
            newc_ff[i] <= '0; curc_ff[i] <= '0; done_ff[i] <= '0;
            qlen_ff[i] <= '0; lkick_ff[i] <= '0;
         end
      end else if (step) begin
         cur_ff <= cur_in; comp_ff <= comp_in; pend_ff <= pend_in;
         wait_ff <= wait_in; idle_ff <= idle_in; per_ff <= per_in;
         if (wr_t) begin
            newc_ff[t[$clog2(NCPU)-1:0]] <= newc_t;
            qlen_ff[t[$clog2(NCPU)-1:0]] <= qlen_t;
         end
         if (wr_c) begin
            seen_ff[c[$clog2(NCPU)-1:0]]  <= seen_c;
            newc_ff[c[$clog2(NCPU)-1:0]]  <= newc_c;
            curc_ff[c[$clog2(NCPU)-1:0]]  <= curc_c;
            done_ff[c[$clog2(NCPU)-1:0]]  <= done_c;
            qlen_ff[c[$clog2(NCPU)-1:0]]  <= qlen_c;
            lkick_ff[c[$clog2(NCPU)-1:0]] <= lkick_c;
            owed_ff[c[$clog2(NCPU)-1:0]]  <= owed_c;
            lift_ff[c[$clog2(NCPU)-1:0]]  <= lift_c;
            armed_ff[c[$clog2(NCPU)-1:0]] <= armed_c;
         end
      end
   end

   // Wait batch has no reset; it is read only after a write.
   always_ff @(posedge clock) begin
      if (step && wr_c) wb_ff[c[$clog2(NCPU)-1:0]] <= wb_c;
   end
endmodule
`default_nettype wire

// ===== rtl/core/rcu_grace_period_tracker_unit.sv =====
// Grace-period tracker top level. An accepted item is held in the input
// register, processed when the result register is free or drains, and its
// result is held in the result register. Throughput: one item per cycle while
// results are taken, set by the single-pass update between the registers.
// Reset is synchronous and active high; it restores the configuration, the
// valid flags and the state but wait batches at once, with no clearing pass.
`default_nettype none
`include "rcu_grace_period_tracker_unit_assert.svh"
module rcu_grace_period_tracker_unit import rgpt_pkg::*; #(
   parameter int NCPU       = NCPU_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   rgpt_req_if.sink                      req,
   rgpt_rsp_if.source                    rsp,
   input  wire logic                     csr_write,
   input  wire logic [CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [CSR_DATA_BITS-1:0] csr_data
);
   cfg_type cfg;
   req_type in_ff;
   logic    in_vld_ff, in_vld_in;
   rsp_type out_ff, core_rsp;
   logic    out_vld_ff, out_vld_in;
   logic    step;

   rgpt_csr u_csr (
      .clock(clock), .reset(reset), .csr_write(csr_write),
      .csr_index(csr_index), .csr_data(csr_data), .cfg(cfg)
   );

   rgpt_core #(.NCPU(NCPU), .COUNT_BITS(COUNT_BITS)) u_core (
      .clock(clock), .reset(reset), .step(step), .req(in_ff), .cfg(cfg),
      .rsp(core_rsp)
   );

   // The staged item moves on when the result register is free or drains.
   assign step       = in_vld_ff && (!out_vld_ff || rsp.ready);
   assign req.ready  = !in_vld_ff || step;
   assign in_vld_in  = (req.valid && req.ready) || (in_vld_ff && !step);
   assign out_vld_in = step || (out_vld_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) in_ff <= req.payload;
      if (step) out_ff <= core_rsp;
   end

   assign rsp.valid   = out_vld_ff;
   assign rsp.payload = out_ff;

   `RGPT_ASSERT_NEXT(a_step_gives_result, clock, reset, step, rsp.valid,
      "processed item produced no result")
   `RGPT_ASSERT_IMPL(a_no_step_on_stall, clock, reset, rsp.valid && !rsp.ready, !step,
      "result overwritten while stalled")
   `RGPT_ASSERT_NEXT(a_stall_holds, clock, reset, rsp.valid && !rsp.ready,
      rsp.valid && $stable(rsp.payload), "stalled result changed")
endmodule
`default_nettype wire

// ===== test/rgpt_tracker_scoreboard.sv =====
// Scoreboard for the grace-period tracker: a behavioral copy of the tracker
// state, the queue of expected result items and the comparison. Needs rgpt_pkg.
`timescale 1ns / 1ps
class rgpt_tracker_scoreboard;
   // Configuration copy.
   logic [9:0]  batch_limit;
   logic [15:0] high_mark;
   logic [15:0] low_mark;
   logic [15:0] kick_interval;
   logic [7:0]  online_mask;
   // Global batch state.
   logic [15:0] cur_batch;
   logic [15:0] done_batch;
   bit          batch_requested;
   logic [7:0]  owe_mask;
   logic [7:0]  idle_cpus;
   logic [16:0] period;
   bit          finished_flag;
   // Per-processor state.
   logic [15:0] seen[8];
   bit          owed[8];
   logic [15:0] target_batch[8];
   logic [15:0] cnt_new[8];
   logic [15:0] cnt_cur[8];
   logic [15:0] cnt_done[8];
   logic [15:0] qlen[8];
   logic [15:0] kick_len[8];
   bit          lifted[8];
   bit          armed[8];

   rgpt_pkg::rsp_type expected_rsps[$];
   int mismatches;

   function new();
      mismatches = 0;
      reset_state();
   endfunction

   function void clear_cpu(int c);
      seen[c] = done_batch;
      owed[c] = 0;
      target_batch[c] = 0;
      cnt_new[c] = 0;
      cnt_cur[c] = 0;
      cnt_done[c] = 0;
      qlen[c] = 0;
      kick_len[c] = 0;
      lifted[c] = 0;
      armed[c] = 0;
   endfunction

   function void reset_state();
      batch_limit = 10;
      high_mark = 10000;
      low_mark = 100;
      kick_interval = 1000;
      online_mask = 1;
      cur_batch = rgpt_pkg::BATCH_RESET;
      done_batch = rgpt_pkg::BATCH_RESET;
      batch_requested = 0;
      owe_mask = 0;
      idle_cpus = 0;
      period = rgpt_pkg::PERIOD_DEF;
      for (int c = 0; c < 8; c++) clear_cpu(c);
   endfunction

   function void write_reg(logic [2:0] idx, logic [15:0] data);
      case (idx)
         rgpt_pkg::CSR_BATCH_LIMIT: batch_limit = data[9:0];
         rgpt_pkg::CSR_HIGH_MARK:   high_mark = data;
         rgpt_pkg::CSR_LOW_MARK:    low_mark = data;
         rgpt_pkg::CSR_KICK_IVL:    kick_interval = data;
         rgpt_pkg::CSR_ONLINE:      online_mask = data[7:0];
         default: ;
      endcase
   endfunction

   function logic [15:0] add_sat(logic [15:0] a, logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? 16'hFFFF : s[15:0];
   endfunction

   function bit earlier(logic [15:0] a, logic [15:0] b);
      logic [15:0] d;
      d = a - b;
      return d[15];
   endfunction

   function void open_batch();
      if (batch_requested && done_batch == cur_batch) begin
         batch_requested = 0;
         cur_batch = cur_batch + 16'd1;
         owe_mask = online_mask & ~idle_cpus;
      end
   endfunction

   function void quiet_point(int c);
      owe_mask[c] = 0;
      if (owe_mask == 0) begin
         if (done_batch != cur_batch) finished_flag = 1;
         done_batch = cur_batch;
         open_batch();
      end
   endfunction

   function bit has_work(int c);
      if (cnt_cur[c] != 0 && !earlier(done_batch, target_batch[c])) return 1;
      if (cnt_cur[c] == 0 && cnt_new[c] != 0) return 1;
      if (cnt_done[c] != 0) return 1;
      return seen[c] != cur_batch || owed[c];
   endfunction

   // Notes an accepted input item and queues the result it causes.
   function void note_request(rgpt_pkg::req_type r);
      rgpt_pkg::rsp_type e;
      int c;
      int t;
      logic [15:0] lim;
      logic [15:0] moved;
      logic [15:0] moved_len;
      e = '0;
      c = r.cpu;
      t = r.target_cpu;
      finished_flag = 0;
      case (r.mode)
         rgpt_pkg::MODE_ENQUEUE: begin
            cnt_new[c] = add_sat(cnt_new[c], 16'd1);
            qlen[c] = add_sat(qlen[c], 16'd1);
            if (qlen[c] > high_mark) begin
               lifted[c] = 1;
               e.self_kick = 1;
               if (int'(qlen[c]) - int'(kick_len[c]) > int'(kick_interval)) begin
                  kick_len[c] = qlen[c];
                  e.kick_mask = owe_mask & ~(8'd1 << c);
               end
            end
         end
         rgpt_pkg::MODE_PROCESS: begin
            if (cnt_cur[c] != 0 && !earlier(done_batch, target_batch[c])) begin
               cnt_done[c] = add_sat(cnt_done[c], cnt_cur[c]);
               cnt_cur[c] = 0;
            end
            if (cnt_new[c] != 0 && cnt_cur[c] == 0) begin
               cnt_cur[c] = cnt_new[c];
               cnt_new[c] = 0;
               target_batch[c] = cur_batch + 16'd1;
               if (!batch_requested) begin
                  batch_requested = 1;
                  open_batch();
               end
            end
            if (seen[c] != cur_batch) begin
               owed[c] = 1;
               seen[c] = cur_batch;
            end else if (owed[c]) begin
               owed[c] = 0;
               quiet_point(c);
            end
            if (cnt_done[c] != 0) begin
               lim = (batch_limit == 0) ? 16'd1 : {6'd0, batch_limit};
               e.invoked_count = cnt_done[c];
               if (!lifted[c] && e.invoked_count > lim) e.invoked_count = lim;
               cnt_done[c] = cnt_done[c] - e.invoked_count;
               qlen[c] = (qlen[c] > e.invoked_count) ? qlen[c] - e.invoked_count : 16'd0;
               if (lifted[c] && qlen[c] <= low_mark) lifted[c] = 0;
               if (cnt_done[c] != 0) begin
                  e.more_done = 1;
                  e.self_kick = 1;
               end
            end
         end
         rgpt_pkg::MODE_IDLE_IN: begin
            idle_cpus[c] = 1;
            if (cnt_cur[c] != 0) armed[c] = 1;
         end
         rgpt_pkg::MODE_IDLE_OUT: begin
            armed[c] = 0;
            idle_cpus[c] = 0;
         end
         rgpt_pkg::MODE_OFFLINE: begin
            armed[c] = 0;
            if (cur_batch != done_batch) quiet_point(c);
            moved = add_sat(add_sat(cnt_done[c], cnt_cur[c]), cnt_new[c]);
            moved_len = qlen[c];
            cnt_done[c] = 0;
            cnt_cur[c] = 0;
            cnt_new[c] = 0;
            qlen[c] = 0;
            cnt_new[t] = add_sat(cnt_new[t], moved);
            qlen[t] = add_sat(qlen[t], moved_len);
         end
         rgpt_pkg::MODE_ONLINE: clear_cpu(c);
         rgpt_pkg::MODE_TIMER: begin
            if (owe_mask != 0)
               period = (period + rgpt_pkg::PERIOD_INC > rgpt_pkg::PERIOD_MAX) ?
                        rgpt_pkg::PERIOD_MAX : period + rgpt_pkg::PERIOD_INC;
            else
               period = (period < rgpt_pkg::PERIOD_MIN + rgpt_pkg::PERIOD_DEC) ?
                        rgpt_pkg::PERIOD_MIN : period - rgpt_pkg::PERIOD_DEC;
         end
         default: ;
      endcase
      e.work_pending = has_work(c);
      e.needs_cpu = (cnt_cur[c] != 0 && !armed[c]) || e.work_pending;
      e.batch_completed = finished_flag;
      e.current_batch_out = cur_batch;
      e.completed_batch_out = done_batch;
      e.idle_period_us = period;
      expected_rsps.push_back(e);
   endfunction

   // Compares one accepted result item with the oldest expectation.
   function void check_response(rgpt_pkg::rsp_type got);
      rgpt_pkg::rsp_type e;
      if (expected_rsps.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("Unexpected result item %h", got);
         return;
      end
      e = expected_rsps.pop_front();
      if (got.invoked_count !== e.invoked_count || got.more_done !== e.more_done ||
          got.kick_mask !== e.kick_mask || got.self_kick !== e.self_kick ||
          got.work_pending !== e.work_pending || got.needs_cpu !== e.needs_cpu ||
          got.batch_completed !== e.batch_completed ||
          got.current_batch_out !== e.current_batch_out ||
          got.completed_batch_out !== e.completed_batch_out ||
          got.idle_period_us !== e.idle_period_us) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("Result mismatch: inv %0d/%0d more %0d/%0d kick %h/%h self %0d/%0d",
                     e.invoked_count, got.invoked_count, e.more_done, got.more_done,
                     e.kick_mask, got.kick_mask, e.self_kick, got.self_kick);
            $display("  pend %0d/%0d needs %0d/%0d cmpl %0d/%0d cur %0d/%0d done %0d/%0d",
                     e.work_pending, got.work_pending, e.needs_cpu, got.needs_cpu,
                     e.batch_completed, got.batch_completed, e.current_batch_out,
                     got.current_batch_out, e.completed_batch_out, got.completed_batch_out);
            $display("  period %0d/%0d", e.idle_period_us, got.idle_period_us);
         end
      end
   endfunction
endclass

// ===== test/testbench.sv =====
// Top-level testbench for the grace-period tracker: drives events and register
// writes, checks every result item. Needs rgpt_pkg, the interfaces and the scoreboard.
`timescale 1ns / 1ps
module testbench;
   import rgpt_pkg::*;

   logic clock;
   logic reset;
   logic csr_write;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0] csr_data;
   int send_idle_pct;
   int recv_stall_pct;
   bit long_hold;
   int quiet_cycles;

   rgpt_req_if req_ch ();
   rgpt_rsp_if rsp_ch ();
   rgpt_tracker_scoreboard tracker;

   rcu_grace_period_tracker_unit u_top (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      tracker = new();
      reset = 1;
      csr_write = 0;
      csr_index = '0;
      csr_data = '0;
      req_ch.valid = 0;
      req_ch.payload = '0;
      rsp_ch.ready = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      long_hold = 0;
   end

   // Receiver: random stalls, and one long hold-off set by the stimulus block.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 0;
      end else if (long_hold) begin
         rsp_ch.ready <= 0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Checks each accepted result item.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) tracker.check_response(rsp_ch.payload);
   end

   // Watchdog over cycles with no accepted item.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 5000) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Sends one input item and notes it when accepted. Valid stays high after
   // acceptance so that items can follow back to back; idling drops it.
   task automatic send_item(logic [2:0] mode, logic [2:0] cpu, logic [2:0] tgt);
      req_type r;
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 0;
         @(posedge clock);
      end
      r.mode = mode;
      r.cpu = cpu;
      r.target_cpu = tgt;
      req_ch.valid <= 1;
      req_ch.payload <= r;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      tracker.note_request(r);
   endtask

   // Waits until every expected result item has come, plus the latency.
   task automatic drain();
      req_ch.valid <= 0;
      while (tracker.expected_rsps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [15:0] data);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      csr_write <= 0;
      tracker.write_reg(idx, data);
      @(posedge clock);
   endtask

   // One random event, weighted toward enqueue and process.
   task automatic random_item();
      int p;
      logic [2:0] m;
      p = $urandom_range(99);
      if (p < 35) m = MODE_ENQUEUE;
      else if (p < 70) m = MODE_PROCESS;
      else if (p < 76) m = MODE_IDLE_IN;
      else if (p < 82) m = MODE_IDLE_OUT;
      else if (p < 86) m = MODE_OFFLINE;
      else if (p < 89) m = MODE_ONLINE;
      else if (p < 96) m = MODE_TIMER;
      else m = MODE_NONE;
      send_item(m, 3'($urandom_range(7)), 3'($urandom_range(7)));
   endtask

   task automatic random_config(bit extreme);
      write_csr(CSR_BATCH_LIMIT, extreme ? ($urandom_range(1) ? 16'd1023 : 16'd1) :
                16'($urandom_range(1, 20)));
      write_csr(CSR_HIGH_MARK, extreme ? ($urandom_range(1) ? 16'd65535 : 16'd1) :
                16'($urandom_range(1, 40)));
      write_csr(CSR_LOW_MARK, extreme ? ($urandom_range(1) ? 16'd65535 : 16'd0) :
                16'($urandom_range(0, 20)));
      write_csr(CSR_KICK_IVL, extreme ? ($urandom_range(1) ? 16'd65535 : 16'd0) :
                16'($urandom_range(0, 10)));
      write_csr(CSR_ONLINE, extreme ? ($urandom_range(1) ? 16'd255 : 16'd0) :
                16'($urandom_range(0, 255)));
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed part: every mode, extreme fields, offline onto itself,
      // a zero batch limit and a timer with nothing waiting.
      write_csr(CSR_ONLINE, 16'h00FF);
      write_csr(CSR_BATCH_LIMIT, 16'd0);
      write_csr(CSR_HIGH_MARK, 16'd2);
      write_csr(CSR_LOW_MARK, 16'd0);
      write_csr(CSR_KICK_IVL, 16'd0);
      send_item(MODE_TIMER, 3'd0, 3'd0);
      send_item(MODE_NONE, 3'd7, 3'd7);
      send_item(MODE_ENQUEUE, 3'd0, 3'd0);
      send_item(MODE_ENQUEUE, 3'd7, 3'd0);
      send_item(MODE_PROCESS, 3'd0, 3'd0);
      send_item(MODE_PROCESS, 3'd7, 3'd0);
      send_item(MODE_ENQUEUE, 3'd0, 3'd0);
      send_item(MODE_ENQUEUE, 3'd0, 3'd0);
      send_item(MODE_TIMER, 3'd3, 3'd0);
      send_item(MODE_IDLE_IN, 3'd7, 3'd0);
      send_item(MODE_IDLE_OUT, 3'd7, 3'd0);
      send_item(MODE_OFFLINE, 3'd7, 3'd7);
      send_item(MODE_OFFLINE, 3'd0, 3'd5);
      send_item(MODE_ONLINE, 3'd7, 3'd0);
      for (int i = 0; i < 8; i++) send_item(MODE_PROCESS, i[2:0], 3'd0);
      drain();

      // Random phases with different idling and configuration.
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0; recv_stall_pct = 0; end
            1: begin send_idle_pct = 73; recv_stall_pct = 0; end
            2: begin send_idle_pct = 0; recv_stall_pct = 73; end
            default: begin send_idle_pct = 11; recv_stall_pct = 11; end
         endcase
         random_config(ph == 3 || ph == 6);
         if (ph == 2) begin
            // The receiver holds off while items keep coming.
            fork
               begin
                  long_hold = 1;
                  repeat (60) @(posedge clock);
                  long_hold = 0;
               end
               for (int i = 0; i < 20; i++) random_item();
            join
         end
         for (int i = 0; i < 128; i++) random_item();
         drain();
      end

      drain();
      if (tracker.mismatches == 0 && tracker.expected_rsps.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
